[hdl/usw_pkg.sv]
// Shared types and constants for the ustar archive stream walker.
// No dependencies.
package usw_pkg;

    localparam int BLOCK_LEN  = 512;
    localparam int NAME_LEN   = 100;
    localparam int SIZE_FIRST = 124;
    localparam int SIZE_LEN   = 11;
    localparam int TYPE_POS   = 156;

    localparam logic [8:0] POS_LAST = 9'(BLOCK_LEN - 1);

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SEVEN = 8'h37;
    localparam logic [7:0] CHR_FIVE  = 8'h35;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_PAD     = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic        is_dir;
        logic [31:0] size;
    } t_hdr_info;

endpackage

[hdl/usw_hdr_fields.sv]
// Header field tracker: name terminator and trailing slash, octal size, typeflag.
// Depends on usw_pkg.
module usw_hdr_fields import usw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_clear,
    input  logic [8:0] i_pos,
    input  logic [7:0] i_byte,
    output t_hdr_info o_info
);

    logic [31:0] r_size;
    logic [31:0] n_size;
    logic        r_oct_stop;
    logic        n_oct_stop;
    logic        r_name_end;
    logic        n_name_end;
    logic        r_slash;
    logic        n_slash;
    logic        r_dir_type;
    logic        n_dir_type;
    logic        w_in_name;
    logic        w_in_size;
    logic        w_octal;

    assign w_in_name = i_pos < 9'(NAME_LEN);
    assign w_in_size = (i_pos >= 9'(SIZE_FIRST)) && (i_pos < 9'(SIZE_FIRST + SIZE_LEN));
    assign w_octal   = (i_byte >= CHR_ZERO) && (i_byte <= CHR_SEVEN);

    always_comb begin
        n_size     = r_size;
        n_oct_stop = r_oct_stop;
        n_name_end = r_name_end;
        n_slash    = r_slash;
        n_dir_type = r_dir_type;
        if (i_clear) begin
            n_size     = '0;
            n_oct_stop = 1'b0;
            n_name_end = 1'b0;
            n_slash    = 1'b0;
            n_dir_type = 1'b0;
        end else if (i_step) begin
            if (w_in_name && !r_name_end) begin
                if (i_byte == CHR_NUL) begin
                    n_name_end = 1'b1;
                end else begin
                    n_slash = (i_byte == CHR_SLASH);
                end
            end
            if (w_in_size && !r_oct_stop) begin
                if (!w_octal) begin
                    n_oct_stop = 1'b1;
                end else begin
                    n_size = {r_size[28:0], 3'(i_byte - CHR_ZERO)};
                end
            end
            if (i_pos == 9'(TYPE_POS)) begin
                n_dir_type = (i_byte == CHR_FIVE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= '0;
            r_oct_stop <= 1'b0;
            r_name_end <= 1'b0;
            r_slash    <= 1'b0;
            r_dir_type <= 1'b0;
        end else begin
            r_size     <= n_size;
            r_oct_stop <= n_oct_stop;
            r_name_end <= n_name_end;
            r_slash    <= n_slash;
            r_dir_type <= n_dir_type;
        end
    end

    assign o_info.size   = r_size;
    assign o_info.is_dir = r_dir_type || r_slash;

endmodule

[hdl/ustar_archive_stream_walker_top.sv]
// Results are registered and reach the master side in the cycle after the input.
// Throughput: one byte per cycle; the single result register refills in the
// cycle it is taken, so only master-side backpressure stalls the input.
// Reset: synchronous, active low; returns to the header phase with all counters
// cleared. A tlast byte also resets the phase, counters and header fields.
module ustar_archive_stream_walker_top import usw_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] byte_value, [16:8] header_offset,
                                        // [17] entry_done, [18] entry_is_dir,
                                        // [50:19] entry_size, [66:51] entry_total,
                                        // [67] archive_empty, [71:68] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
    output logic        m_axis_tlast    // archive_done
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [1:0]            r_phase;
    logic [1:0]            n_phase;
    logic [8:0]            r_pos;
    logic [8:0]            n_pos;
    logic [31:0]           r_data_left;
    logic [31:0]           n_data_left;
    logic [8:0]            r_pad_left;
    logic [8:0]            n_pad_left;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] w_cnt_upd;
    logic [31:0]           w_cnt_ext;
    logic [31:0]           w_dl_dec;
    logic [8:0]            w_pad_dec;

    logic                  r_out_valid;
    logic [71:0]           r_out_data;
    logic [71:0]           n_out_data;
    logic [1:0]            r_out_kind;
    logic [1:0]            n_out_kind;
    logic                  r_out_last;

    logic                  w_accept;
    logic                  w_end_mark;
    logic                  w_hdr_byte;
    logic                  w_hdr_done;
    logic [8:0]            w_offs;
    logic                  w_done;
    logic                  w_is_dir;
    logic [31:0]           w_esize;
    logic [15:0]           w_total;
    logic                  w_empty;
    t_hdr_info             w_info;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_end_mark = (r_phase == PH_HEADER) && (r_pos == 9'd0) && (s_axis_tdata == CHR_NUL);
    assign w_hdr_byte = (r_phase == PH_HEADER) && !w_end_mark;
    assign w_hdr_done = w_hdr_byte && (r_pos == POS_LAST);

    usw_hdr_fields u_hdr_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept && w_hdr_byte && !w_hdr_done),
        .i_clear (w_accept && (w_hdr_done || s_axis_tlast)),
        .i_pos   (r_pos),
        .i_byte  (s_axis_tdata),
        .o_info  (w_info)
    );

    assign w_dl_dec  = (r_data_left != 32'd0) ? r_data_left - 32'd1 : r_data_left;
    assign w_pad_dec = (r_pad_left != 9'd0) ? r_pad_left - 9'd1 : r_pad_left;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_data_left = r_data_left;
        n_pad_left  = r_pad_left;
        w_cnt_upd   = r_cnt;
        n_out_kind  = KIND_IGNORED;
        w_offs      = 9'd0;
        w_done      = 1'b0;
        w_is_dir    = 1'b0;
        w_esize     = 32'd0;
        case (r_phase)
            PH_HEADER: begin
                if (w_end_mark) begin
                    n_phase = PH_END;
                end else begin
                    n_out_kind = KIND_HEADER;
                    w_offs     = r_pos;
                    if (w_hdr_done) begin
                        w_done      = 1'b1;
                        w_is_dir    = w_info.is_dir;
                        w_esize     = w_info.size;
                        w_cnt_upd   = (r_cnt != CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
                        n_data_left = w_info.size;
                        n_pad_left  = 9'(~w_info.size[8:0]) + 9'd1;
                        n_phase     = (w_info.size != 32'd0) ? PH_DATA : PH_HEADER;
                        n_pos       = 9'd0;
                    end else begin
                        n_pos = r_pos + 9'd1;
                    end
                end
            end
            PH_DATA: begin
                n_out_kind  = KIND_DATA;
                n_data_left = w_dl_dec;
                if (w_dl_dec == 32'd0) begin
                    n_phase = (r_pad_left != 9'd0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                n_out_kind = KIND_PAD;
                n_pad_left = w_pad_dec;
                if (w_pad_dec == 9'd0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_out_kind = KIND_IGNORED;
            end
        endcase
        n_cnt = w_cnt_upd;
        if (s_axis_tlast) begin
            n_phase     = PH_HEADER;
            n_pos       = 9'd0;
            n_data_left = 32'd0;
            n_pad_left  = 9'd0;
            n_cnt       = '0;
        end
    end

    assign w_cnt_ext = 32'(w_cnt_upd);
    assign w_total   = (w_cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : w_cnt_ext[15:0];
    assign w_empty   = s_axis_tlast && (w_cnt_upd == '0);

    assign n_out_data = {4'd0, w_empty, w_total, w_esize, w_is_dir, w_done, w_offs,
                         s_axis_tdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= 9'd0;
            r_data_left <= 32'd0;
            r_pad_left  <= 9'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_data_left <= n_data_left;
                r_pad_left  <= n_pad_left;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            r_out_kind <= n_out_kind;
            r_out_last <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
